// File: src/pba_pkg.sv
package pba_pkg;

   localparam int MAX_BINS    = 64;
   localparam int SAMPLE_BITS = 24;
   localparam int PHASE_BITS  = 16;
   localparam int COUNT_BITS  = 24;
   localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
   localparam int IDX_BITS    = $clog2(MAX_BINS);
   localparam int NB_BITS     = 7;
   localparam int PROD_BITS   = PHASE_BITS + NB_BITS;
   localparam int STEP_BITS   = $clog2(SAMPLE_BITS + 1);

   localparam logic [NB_BITS-1:0]    NUM_BINS_RESET = NB_BITS'(MAX_BINS);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX      = '1;

   typedef enum logic {
      OP_ACCUM = 1'b0,
      OP_EMIT  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_READ,
      ST_LOAD,
      ST_DIVIDE,
      ST_PUT
   } state_type;

   // One bin of the store.
   typedef struct packed {
      logic signed [SUM_BITS-1:0] sum;
      logic [COUNT_BITS-1:0]      hits;
      logic                       overflow;
   } bin_entry_type;

   // Zero selects one bin, anything above the store depth selects all bins.
   function automatic logic [NB_BITS-1:0] bins_in_use(input logic [NB_BITS-1:0] nb);
      logic [NB_BITS-1:0] n;
      n = nb;
      if (nb == '0) begin
         n = NB_BITS'(1);
      end else if (nb > NB_BITS'(MAX_BINS)) begin
         n = NB_BITS'(MAX_BINS);
      end
      return n;
   endfunction

   // bin = phase * n >> PHASE_BITS; with n at most MAX_BINS it always fits.
   function automatic logic [IDX_BITS-1:0] phase_to_bin(input logic [PHASE_BITS-1:0] phase,
                                                        input logic [NB_BITS-1:0]    n);
      logic [PROD_BITS-1:0] prod;
      prod = PROD_BITS'(phase) * PROD_BITS'(n);
      return prod[PHASE_BITS +: IDX_BITS];
   endfunction

endpackage

// File: src/pba_req_if.sv
interface pba_req_if;
   logic                                    valid;
   logic                                    ready;
   pba_pkg::op_type                         op;
   logic signed [pba_pkg::SAMPLE_BITS-1:0]  sample;
   logic [pba_pkg::PHASE_BITS-1:0]          phase;
   logic                                    discard;

   modport source (output valid, op, sample, phase, discard, input ready);
   modport sink   (input valid, op, sample, phase, discard, output ready);
endinterface

// File: src/pba_rsp_if.sv
interface pba_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [pba_pkg::IDX_BITS-1:0]            bin_index;
   logic signed [pba_pkg::SAMPLE_BITS-1:0]  mean;
   logic [pba_pkg::COUNT_BITS-1:0]          hits;
   logic                                    empty_res;
   logic                                    overflow;
   logic                                    last;

   modport source (output valid, bin_index, mean, hits, empty_res, overflow, last,
                   input ready);
   modport sink   (input valid, bin_index, mean, hits, empty_res, overflow, last,
                   output ready);
endinterface

// File: src/pba_ram.sv
module pba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents when the same entry is written in that cycle.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/pba_div.sv
module pba_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pba_pkg::SUM_BITS-1:0]     dividend,
   input  logic [pba_pkg::COUNT_BITS-1:0]   divisor,
   output logic                             busy,
   output logic [pba_pkg::SAMPLE_BITS-1:0]  quotient
);

   // Restoring division, one quotient bit per cycle. The quotient is known to
   // fit in SAMPLE_BITS, so the upper part of the dividend starts as the
   // partial remainder and only SAMPLE_BITS steps are needed.
   logic                               busy_ff;
   logic [pba_pkg::STEP_BITS-1:0]      step_ff;
   logic [pba_pkg::COUNT_BITS-1:0]     rem_ff;
   logic [pba_pkg::SAMPLE_BITS-1:0]    quo_ff;
   logic [pba_pkg::COUNT_BITS-1:0]     div_ff;
   logic [pba_pkg::COUNT_BITS:0]       trial;
   logic [pba_pkg::COUNT_BITS:0]       diff;
   logic                               ge;

   always_comb begin
      trial = {rem_ff, quo_ff[pba_pkg::SAMPLE_BITS-1]};
      diff  = trial - {1'b0, div_ff};
      ge    = trial >= {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (step_ff == pba_pkg::STEP_BITS'(pba_pkg::SAMPLE_BITS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[pba_pkg::SUM_BITS-1:pba_pkg::SAMPLE_BITS];
         quo_ff <= dividend[pba_pkg::SAMPLE_BITS-1:0];
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[pba_pkg::COUNT_BITS-1:0] : trial[pba_pkg::COUNT_BITS-1:0];
         quo_ff <= {quo_ff[pba_pkg::SAMPLE_BITS-2:0], ge};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// File: src/phase_bin_averager.sv
// Phase-binned averager for a sample stream over one ring.
// The req_chan channel takes one transaction per item. An accumulate
// transaction (op clear) adds its sample to the bin chosen by its phase,
// unless discard is set; it is taken in every cycle while the block is not
// emitting, and is written into the bin store in the cycle after it is taken.
// An end-of-ring transaction (op set) makes the block report every bin in
// use, in bin order, on rsp_chan, then empties all bins. The last report
// carries last. Each bin's entry is read from the single-port-read store and
// its mean comes from a serial divider that produces one quotient bit per
// cycle. No new transaction is taken on req_chan during the drain.
// Results sit in an output register; when the receiver stalls the drain
// waits on that register, and after the final report is loaded the block
// takes new samples again even if that report has not yet been taken.
// Reset (synchronous) empties every bin at once and sets num_bins to 64.
// num_bins is written through csr_wr_en and csr_wr_data; the user must do
// so only while idle, since the block itself does not enforce it.
module phase_bin_averager (
   input  logic                         clock,
   input  logic                         reset,
   pba_req_if.sink                      req_chan,
   pba_rsp_if.source                    rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [pba_pkg::NB_BITS-1:0]  csr_wr_data
);

   localparam int EW = $bits(pba_pkg::bin_entry_type);

   pba_pkg::state_type                    state_ff, state_in;
   logic [pba_pkg::NB_BITS-1:0]           num_bins_ff;
   logic [pba_pkg::NB_BITS-1:0]           n_use;

   // Per-bin valid bits: a bin that is not valid reads as empty, so the whole
   // store is cleared at once by clearing these bits.
   logic [pba_pkg::MAX_BINS-1:0]          valid_ff;

   logic                                  req_fire;
   logic                                  acc_go;
   logic                                  emit_go;
   logic [pba_pkg::IDX_BITS-1:0]          acc_bin;

   // Accumulate pipeline: the entry is read in the cycle of the transaction
   // and written back in the cycle after it.
   logic                                  s1_valid_ff;
   logic [pba_pkg::IDX_BITS-1:0]          s1_bin_ff;
   logic signed [pba_pkg::SAMPLE_BITS-1:0] s1_sample_ff;
   logic                                  fwd_ff;
   pba_pkg::bin_entry_type                wr_last_ff;
   pba_pkg::bin_entry_type                old_entry;
   pba_pkg::bin_entry_type                new_entry;

   // Store port signals.
   logic [pba_pkg::IDX_BITS-1:0]          rd_addr;
   logic [EW-1:0]                         rd_raw;
   pba_pkg::bin_entry_type                rd_entry;

   // Drain path.
   logic [pba_pkg::IDX_BITS-1:0]          idx_ff;
   logic                                  cur_neg_ff;
   logic                                  cur_ovf_ff;
   logic [pba_pkg::COUNT_BITS-1:0]        cur_hits_ff;
   pba_pkg::bin_entry_type                ld_entry;
   logic [pba_pkg::SUM_BITS-1:0]          ld_mag;
   logic                                  div_start;
   logic                                  div_busy;
   logic [pba_pkg::SAMPLE_BITS-1:0]       div_quo;
   logic                                  out_free;
   logic                                  put_fire;
   logic                                  put_last;
   logic signed [pba_pkg::SAMPLE_BITS-1:0] put_mean;

   // Output register.
   logic                                  rsp_valid_ff;
   logic [pba_pkg::IDX_BITS-1:0]          rsp_bin_ff;
   logic signed [pba_pkg::SAMPLE_BITS-1:0] rsp_mean_ff;
   logic [pba_pkg::COUNT_BITS-1:0]        rsp_hits_ff;
   logic                                  rsp_empty_ff;
   logic                                  rsp_ovf_ff;
   logic                                  rsp_last_ff;

   assign n_use    = pba_pkg::bins_in_use(num_bins_ff);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign acc_go   = req_fire && (req_chan.op == pba_pkg::OP_ACCUM) && !req_chan.discard;
   assign emit_go  = req_fire && (req_chan.op == pba_pkg::OP_EMIT);
   assign acc_bin  = pba_pkg::phase_to_bin(req_chan.phase, n_use);
   assign req_chan.ready = (state_ff == pba_pkg::ST_ACCUM);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_bins_ff <= pba_pkg::NUM_BINS_RESET;
      end else if (csr_wr_en) begin
         num_bins_ff <= csr_wr_data;
      end
   end

   // Bin store.
   assign rd_addr  = (state_ff == pba_pkg::ST_ACCUM) ? acc_bin : idx_ff;
   assign rd_entry = pba_pkg::bin_entry_type'(rd_raw);

   pba_ram #(
      .WIDTH (EW),
      .DEPTH (pba_pkg::MAX_BINS)
   ) u_pba_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_bin_ff),
      .wr_data (EW'(new_entry)),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // Read-modify-write. When the previous sample went to the same bin, its
   // write lands in the same cycle as this read, so the written value is
   // taken from wr_last_ff instead of the store.
   always_comb begin
      if (fwd_ff) begin
         old_entry = wr_last_ff;
      end else if (valid_ff[s1_bin_ff]) begin
         old_entry = rd_entry;
      end else begin
         old_entry = '0;
      end
      new_entry = old_entry;
      if (old_entry.hits == pba_pkg::COUNT_MAX) begin
         new_entry.overflow = 1'b1;
      end else begin
         new_entry.sum  = old_entry.sum
                        + {{pba_pkg::COUNT_BITS{s1_sample_ff[pba_pkg::SAMPLE_BITS-1]}},
                           s1_sample_ff};
         new_entry.hits = old_entry.hits + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= acc_go;
         fwd_ff      <= acc_go && s1_valid_ff && (s1_bin_ff == acc_bin);
      end
   end

   always_ff @(posedge clock) begin
      if (acc_go) begin
         s1_bin_ff    <= acc_bin;
         s1_sample_ff <= req_chan.sample;
      end
      if (s1_valid_ff) begin
         wr_last_ff <= new_entry;
      end
   end

   // Drain: read the bin, split sign and magnitude, divide, then report.
   always_comb begin
      ld_entry = valid_ff[idx_ff] ? rd_entry : '0;
      ld_mag   = ld_entry.sum[pba_pkg::SUM_BITS-1] ? (pba_pkg::SUM_BITS'(0) - ld_entry.sum)
                                                   : ld_entry.sum;
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign put_last = ({1'b0, idx_ff} == n_use - 1'b1);

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      put_fire  = 1'b0;
      case (state_ff)
         pba_pkg::ST_ACCUM: begin
            if (emit_go) begin
               state_in = pba_pkg::ST_READ;
            end
         end
         pba_pkg::ST_READ: begin
            state_in = pba_pkg::ST_LOAD;
         end
         pba_pkg::ST_LOAD: begin
            div_start = (ld_entry.hits != '0);
            state_in  = pba_pkg::ST_DIVIDE;
         end
         pba_pkg::ST_DIVIDE: begin
            if (!div_busy) begin
               state_in = pba_pkg::ST_PUT;
            end
         end
         pba_pkg::ST_PUT: begin
            if (out_free) begin
               put_fire = 1'b1;
               state_in = put_last ? pba_pkg::ST_ACCUM : pba_pkg::ST_READ;
            end
         end
         default: begin
            state_in = pba_pkg::ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pba_pkg::ST_ACCUM;
         idx_ff   <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (emit_go) begin
            idx_ff <= '0;
         end else if (put_fire) begin
            idx_ff <= idx_ff + 1'b1;
         end
         // The end of the drain empties every bin, also those not reported.
         if (put_fire && put_last) begin
            valid_ff <= '0;
         end else if (s1_valid_ff) begin
            valid_ff[s1_bin_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == pba_pkg::ST_LOAD) begin
         cur_neg_ff  <= ld_entry.sum[pba_pkg::SUM_BITS-1];
         cur_ovf_ff  <= ld_entry.overflow;
         cur_hits_ff <= ld_entry.hits;
      end
   end

   pba_div u_pba_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ld_mag),
      .divisor  (ld_entry.hits),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // Truncation toward zero: divide the magnitude, then restore the sign.
   always_comb begin
      if (cur_hits_ff == '0) begin
         put_mean = '0;
      end else if (cur_neg_ff) begin
         put_mean = pba_pkg::SAMPLE_BITS'(0) - div_quo;
      end else begin
         put_mean = div_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (put_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (put_fire) begin
         rsp_bin_ff   <= idx_ff;
         rsp_mean_ff  <= put_mean;
         rsp_hits_ff  <= cur_hits_ff;
         rsp_empty_ff <= (cur_hits_ff == '0);
         rsp_ovf_ff   <= cur_ovf_ff;
         rsp_last_ff  <= put_last;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.bin_index = rsp_bin_ff;
   assign rsp_chan.mean      = rsp_mean_ff;
   assign rsp_chan.hits      = rsp_hits_ff;
   assign rsp_chan.empty_res = rsp_empty_ff;
   assign rsp_chan.overflow  = rsp_ovf_ff;
   assign rsp_chan.last      = rsp_last_ff;

endmodule

// File: src/pba_checker.sv
module pba_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [pba_pkg::SAMPLE_BITS-1:0]  rsp_mean,
   input logic [pba_pkg::COUNT_BITS-1:0]          rsp_hits,
   input logic                                    rsp_empty_res,
   input logic                                    rsp_overflow,
   input logic                                    rsp_last
);

   // A stalled result stays on the port unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mean) && $stable(rsp_hits)
                                  && $stable(rsp_last))
      else $error("stalled result changed");

   // An empty bin reports zero mean and never a dropped sample.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_hits == '0 && rsp_mean == '0 && !rsp_overflow)
      else $error("empty bin reported with data");

   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_empty_res |-> rsp_hits != '0)
      else $error("non-empty bin without hits");

   // Samples are only dropped once the count has saturated.
   a_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_hits == pba_pkg::COUNT_MAX)
      else $error("overflow flagged below saturation");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

endmodule

bind phase_bin_averager pba_checker u_pba_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_mean      (rsp_chan.mean),
   .rsp_hits      (rsp_chan.hits),
   .rsp_empty_res (rsp_chan.empty_res),
   .rsp_overflow  (rsp_chan.overflow),
   .rsp_last      (rsp_chan.last)
);
